// ===== sv/bisoe_pkg.sv =====
// Shared types and constants for the bounded id set with oldest-first eviction.
package bisoe_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned S_TDATA_W  = 64;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic present;
    logic changed;
    logic evicted;
  } flags_t;

endpackage

// ===== sv/bisoe_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bisoe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/bounded_id_set_oldest_eviction.sv =====
// Top level of the bounded id set with oldest-first eviction and its sequencer.
//
//  Channel  Direction  tdata (low bit up)                            tuser
//  s_axis   in         key[63:0]                                     opcode[1:0]
//  m_axis   out        present, changed, evicted, entry_count[4:0]   -
//
// Each item searches the stored entries one at a time, a read and then a compare per
// entry, and a remove or an eviction closes the gap by moving each later entry down,
// a read and then a write per entry, since the key RAM has a single port pair.
// Clear skips the search. After reset the set is empty and the block is ready at once.
// A result waits in the output register while the next beat is accepted; a stalled
// result only holds the block once the following item is finished.
module bounded_id_set_oldest_eviction
  import bisoe_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // key[63:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // opcode[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // present, changed, evicted, entry_count[4:0]
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
  localparam logic [CW-1:0] One = CW'(1);

  state_e                state_q, state_d;
  opcode_e               op_q, op_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  flags_t                flags_q, flags_d;
  logic                  m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0]  m_data_q, m_data_d;

  logic                  ram_wr_en;
  logic [IW-1:0]         ram_wr_addr;
  logic [KEY_BITS-1:0]   ram_wr_data;
  logic                  ram_rd_en;
  logic [IW-1:0]         ram_rd_addr;
  logic [KEY_BITS-1:0]   ram_rd_data;

  logic [CW-1:0]         idx_inc;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign idx_inc = idx_q + One;
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_q};

  bisoe_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(CAPACITY)
  ) u_key_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(ram_wr_data),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    idx_q    <= idx_d;
    flags_q  <= flags_d;
    m_data_q <= m_data_d;
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    key_d         = key_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    flags_d       = flags_q;
    m_valid_d     = m_valid_q;
    m_data_d      = m_data_q;
    s_axis_tready = 1'b0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_q[IW-1:0];
    ram_wr_data   = ram_rd_data;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_q[IW-1:0];

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = opcode_e'(s_axis_tuser);
          key_d   = s_axis_tdata[KEY_BITS-1:0];
          idx_d   = '0;
          flags_d = '0;
          if (opcode_e'(s_axis_tuser) == OP_CLEAR) begin
            flags_d.changed = (cnt_q != '0);
            cnt_d           = '0;
            state_d         = ST_RESP;
          end else begin
            state_d = ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD: begin
        if (key_q == '0 || idx_q >= cnt_q) begin
          if (op_q == OP_INSERT && key_q != '0) begin
            if (cnt_q == CapCount) begin
              flags_d.evicted = 1'b1;
              idx_d           = '0;
              state_d         = ST_SHIFT_RD;
            end else begin
              state_d = ST_APPEND;
            end
          end else begin
            state_d = ST_RESP;
          end
        end else begin
          ram_rd_en = 1'b1;
          state_d   = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (ram_rd_data == key_q) begin
          flags_d.present = 1'b1;
          if (op_q == OP_REMOVE) begin
            state_d = ST_SHIFT_RD;
          end else begin
            state_d = ST_RESP;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = ST_SRCH_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (idx_inc < cnt_q) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_inc[IW-1:0];
          state_d     = ST_SHIFT_WR;
        end else begin
          cnt_d = cnt_q - One;
          if (flags_q.evicted) begin
            state_d = ST_APPEND;
          end else begin
            flags_d.changed = 1'b1;
            state_d         = ST_RESP;
          end
        end
      end
      ST_SHIFT_WR: begin
        ram_wr_en = 1'b1;
        idx_d     = idx_inc;
        state_d   = ST_SHIFT_RD;
      end
      ST_APPEND: begin
        ram_wr_en       = 1'b1;
        ram_wr_addr     = cnt_q[IW-1:0];
        ram_wr_data     = key_q;
        cnt_d           = cnt_q + One;
        flags_d.changed = 1'b1;
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {cnt_ext[COUNT_W-1:0], flags_q.evicted, flags_q.changed,
                       flags_q.present};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== sim/bisoe_result_checker.sv =====
// Checker for the bounded id set: tracks the key set, predicts each result and compares it.
module bisoe_result_checker
  import bisoe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // key[63:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // opcode[1:0]
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,   // present, changed, evicted, entry_count[4:0]
  output int unsigned          mismatch_count,
  output int unsigned          outstanding
);

  localparam int unsigned SET_DEPTH = 16;

  typedef struct packed {
    logic               present;
    logic               changed;
    logic               evicted;
    logic [COUNT_W-1:0] entry_count;
  } set_outcome_t;

  logic [KEY_W-1:0] held_keys [SET_DEPTH];
  int unsigned      held_num;
  set_outcome_t     outcome_q [$];

  function automatic set_outcome_t apply_set_op(input opcode_e op, input logic [KEY_W-1:0] key);
    set_outcome_t res;
    logic         found;
    int unsigned  pos;
    res   = '0;
    found = 1'b0;
    pos   = 0;
    if (key != '0) begin
      for (int unsigned i = 0; i < held_num; i++) begin
        if (!found && held_keys[i] == key) begin
          found = 1'b1;
          pos   = i;
        end
      end
    end
    case (op)
      OP_LOOKUP: begin
        res.present = found;
      end
      OP_INSERT: begin
        res.present = found;
        if (key != '0 && !found) begin
          if (held_num >= SET_DEPTH) begin
            for (int unsigned j = 0; j + 1 < SET_DEPTH; j++) held_keys[j] = held_keys[j+1];
            held_num    = SET_DEPTH - 1;
            res.evicted = 1'b1;
          end
          held_keys[held_num] = key;
          held_num++;
          res.changed = 1'b1;
        end
      end
      OP_REMOVE: begin
        res.present = found;
        if (found) begin
          for (int unsigned j = pos; j + 1 < held_num; j++) held_keys[j] = held_keys[j+1];
          held_num--;
          res.changed = 1'b1;
        end
      end
      default: begin
        res.changed = (held_num != 0);
        held_num    = 0;
      end
    endcase
    res.entry_count = held_num[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    set_outcome_t want;
    set_outcome_t got;
    if (!rst_ni) begin
      held_num = 0;
      outcome_q.delete();
      outstanding    = 0;
      mismatch_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.present     = m_axis_tdata[0];
        got.changed     = m_axis_tdata[1];
        got.evicted     = m_axis_tdata[2];
        got.entry_count = m_axis_tdata[7:3];
        if (outcome_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result beat with no outstanding request: %s%0b %s%0b %s%0b %s%0d",
                     "present=", got.present, "changed=", got.changed,
                     "evicted=", got.evicted, "count=", got.entry_count);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected present=%0b changed=%0b evicted=%0b count=%0d",
                       want.present, want.changed, want.evicted, want.entry_count);
              $display("          got      present=%0b changed=%0b evicted=%0b count=%0d",
                       got.present, got.changed, got.evicted, got.entry_count);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        outcome_q.push_back(apply_set_op(opcode_e'(s_axis_tuser), s_axis_tdata[KEY_W-1:0]));
      outstanding = outcome_q.size();
    end
  end

endmodule

// ===== sim/bounded_id_set_oldest_eviction_tb.sv =====
// Testbench top for the bounded id set: clock, reset, request stimulus, stall pattern and verdict.
module bounded_id_set_oldest_eviction_tb
  import bisoe_pkg::*;
();

  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned RANDOM_BEATS = 650;
  localparam int unsigned DRAIN_CYCLES = 4 * 16 + 8;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // key[63:0]
  logic [S_TUSER_W-1:0] s_axis_tuser;   // opcode[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // present, changed, evicted, entry_count[4:0]

  int unsigned      mismatch_count;
  int unsigned      outstanding;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  bounded_id_set_oldest_eviction DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bisoe_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("** bounded_id_set_oldest_eviction: FAILED **");
    $finish;
  end

  // The receiver switches between always ready, random stalls, long stalls and toggling.
  initial begin
    int unsigned mode;
    int unsigned span;
    m_axis_tready = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
      end
      span--;
      case (mode)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = ($urandom_range(0, 1) == 1);
        2:       m_axis_tready = ($urandom_range(0, 7) == 0);
        default: m_axis_tready = ~m_axis_tready;
      endcase
    end
  end

  // Drives one request beat and holds it until accepted; returns at the next falling edge.
  task automatic push_beat(input opcode_e op, input logic [KEY_W-1:0] key);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = key;
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 12) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic opcode_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_INSERT;
    if (r < 70) return OP_LOOKUP;
    if (r < 98) return OP_REMOVE;
    return OP_CLEAR;
  endfunction

  initial begin
    int unsigned burst_left;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOOKUP;
    rst_ni        = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i] == '0 || key_pool[i] == '1 || key_pool[i] == 64'd1) key_pool[i] = 64'd2 + i;
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    push_beat(OP_LOOKUP, '0);
    push_beat(OP_CLEAR, '0);
    push_beat(OP_INSERT, '1);
    push_beat(OP_INSERT, 64'd1);
    push_beat(OP_INSERT, '1);
    push_beat(OP_INSERT, '0);
    push_beat(OP_LOOKUP, '1);
    push_beat(OP_LOOKUP, key_pool[0]);
    push_beat(OP_LOOKUP, '0);
    push_beat(OP_REMOVE, '0);
    push_beat(OP_REMOVE, key_pool[0]);
    for (int i = 0; i < 15; i++) push_beat(OP_INSERT, key_pool[i]);
    push_beat(OP_REMOVE, key_pool[7]);
    push_beat(OP_CLEAR, '1);

    burst_left = $urandom_range(1, 24);
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          s_axis_tvalid = 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk_i);
        end
      end
      push_beat(pick_op(), pick_key());
      burst_left--;
    end
    s_axis_tvalid = 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** bounded_id_set_oldest_eviction: PASSED **");
    end else begin
      $display("** bounded_id_set_oldest_eviction: FAILED **");
    end
    $finish;
  end

endmodule
